// ===== hdl/ytpq_pkg.sv =====
// Shared types, codes and command/status bundles for the Young tableau queue.
`timescale 1ns / 1ps
`default_nettype none
package ytpq_pkg;

   typedef logic signed [31:0] value_type;

   localparam value_type EMPTY_MARK = 32'sh7fff_ffff;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_EXTRACT = 2'd1;
   localparam logic [1:0] OP_SEARCH  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef struct packed {
      logic load;
      logic rd_nbr;
      logic clr_step;
      logic sift;
      logic srch_left;
      logic srch_down;
      logic set_full;
      logic set_empty;
      logic cap_min;
      logic set_found;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       val_empty;
      logic       cell_empty;
      logic       sift_move;
      logic       hit;
      logic       cell_gt;
      logic       at_left;
      logic       at_bottom;
      logic       clr_last;
      logic       out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== hdl/ytpq_ram.sv =====
// Generic RAM, one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module ytpq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr_a,
   input  wire logic [ADDR_W-1:0] raddr_b,
   output logic      [WIDTH-1:0]  rdata_a,
   output logic      [WIDTH-1:0]  rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule
`default_nettype wire

// ===== hdl/ytpq_ctrl.sv =====
// Controller state machine for the Young tableau queue.
`timescale 1ns / 1ps
`default_nettype none
module ytpq_ctrl import ytpq_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DISPATCH = 3'd2;
   localparam logic [2:0] S_CHECK    = 3'd3;
   localparam logic [2:0] S_SIFT     = 3'd4;
   localparam logic [2:0] S_SEARCH   = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op) inside
               OP_INSERT, OP_EXTRACT: state_in = S_CHECK;
               OP_SEARCH: state_in = stat.val_empty ? S_FINISH : S_SEARCH;
               default: state_in = S_FINISH;
            endcase
         end
         S_CHECK: begin
            if (stat.op == OP_INSERT) begin
               if (!stat.cell_empty) begin
                  cmd.set_full = 1'b1;
                  state_in     = S_FINISH;
               end else begin
                  cmd.rd_nbr = 1'b1;
                  state_in   = S_SIFT;
               end
            end else begin
               if (stat.cell_empty) begin
                  cmd.set_empty = 1'b1;
                  state_in      = S_FINISH;
               end else begin
                  cmd.cap_min = 1'b1;
                  cmd.rd_nbr  = 1'b1;
                  state_in    = S_SIFT;
               end
            end
         end
         S_SIFT: begin
            cmd.sift   = 1'b1;
            cmd.rd_nbr = 1'b1;
            if (!stat.sift_move) begin
               state_in = S_FINISH;
            end
         end
         S_SEARCH: begin
            if (stat.hit) begin
               cmd.set_found = 1'b1;
               state_in      = S_FINISH;
            end else if (stat.cell_gt) begin
               if (stat.at_left) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.srch_left = 1'b1;
               end
            end else begin
               if (stat.at_bottom) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.srch_down = 1'b1;
               end
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ytpq_datapath.sv =====
// Datapath: cell memory, walk position, sift compare and result registers.
`timescale 1ns / 1ps
`default_nettype none
module ytpq_datapath import ytpq_pkg::*; #(
   parameter int ROWS = 8,
   parameter int COLS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire cmd_type                cmd,
   output stat_type                    stat
);

   localparam int DEPTH  = ROWS * COLS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0]  ROW_ONE   = ROW_W'(1);
   localparam logic [COL_W-1:0]  COL_ONE   = COL_W'(1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ADDR_COLS = ADDR_W'(COLS);
   localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);

   logic [1:0]        op_ff;
   value_type         val_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   value_type         res_ff;
   logic              found_ff;
   logic [1:0]        status_ff;
   logic              rsp_valid_ff;
   value_type         rsp_res_ff;
   logic              rsp_found_ff;
   logic [1:0]        rsp_status_ff;

   logic [1:0]        req_mode;
   value_type         req_value;
   logic [31:0]       ram_a, ram_b;
   value_type         rd_a, rd_b;
   logic [ADDR_W-1:0] raddr_a, raddr_b;
   logic              ram_we;
   value_type         ram_wdata;

   logic              is_ins;
   value_type         mover;
   value_type         best;
   value_type         nbr_val;
   logic              a_ok, b_ok, a_take, b_take, sift_move;

   assign req_mode  = req_tdata[1:0];
   assign req_value = signed'(req_tdata[33:2]);
   assign rd_a      = signed'(ram_a);
   assign rd_b      = signed'(ram_b);

   // Insert moves the new value up or left; extract moves the hole right or down.
   always_comb begin
      is_ins    = (op_ff == OP_INSERT);
      mover     = is_ins ? val_ff : EMPTY_MARK;
      a_ok      = is_ins ? (row_ff != '0) : (col_ff != COL_LAST);
      b_ok      = is_ins ? (col_ff != '0) : (row_ff != ROW_LAST);
      a_take    = a_ok && (is_ins ? (rd_a > mover) : (rd_a < mover));
      best      = a_take ? rd_a : mover;
      b_take    = b_ok && (is_ins ? (rd_b > best) : (rd_b < best));
      sift_move = a_take || b_take;
      nbr_val   = b_take ? rd_b : rd_a;
   end

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      addr_in = addr_ff;
      if (cmd.load) begin
         case (req_mode)
            OP_INSERT: begin
               row_in  = ROW_LAST;
               col_in  = COL_LAST;
               addr_in = ADDR_LAST;
            end
            OP_EXTRACT: begin
               row_in  = '0;
               col_in  = '0;
               addr_in = '0;
            end
            default: begin
               row_in  = '0;
               col_in  = COL_LAST;
               addr_in = ADDR_W'(COLS - 1);
            end
         endcase
      end else if (cmd.clr_step) begin
         addr_in = addr_ff + ADDR_ONE;
      end else if (cmd.sift && sift_move) begin
         if (b_take) begin
            if (is_ins) begin
               col_in  = col_ff - COL_ONE;
               addr_in = addr_ff - ADDR_ONE;
            end else begin
               row_in  = row_ff + ROW_ONE;
               addr_in = addr_ff + ADDR_COLS;
            end
         end else begin
            if (is_ins) begin
               row_in  = row_ff - ROW_ONE;
               addr_in = addr_ff - ADDR_COLS;
            end else begin
               col_in  = col_ff + COL_ONE;
               addr_in = addr_ff + ADDR_ONE;
            end
         end
      end else if (cmd.srch_left) begin
         col_in  = col_ff - COL_ONE;
         addr_in = addr_ff - ADDR_ONE;
      end else if (cmd.srch_down) begin
         row_in  = row_ff + ROW_ONE;
         addr_in = addr_ff + ADDR_COLS;
      end
   end

   always_comb begin
      if (cmd.rd_nbr) begin
         raddr_a = is_ins ? (addr_in - ADDR_COLS) : (addr_in + ADDR_ONE);
         raddr_b = is_ins ? (addr_in - ADDR_ONE) : (addr_in + ADDR_COLS);
      end else begin
         raddr_a = addr_in;
         raddr_b = addr_in;
      end
      ram_we    = cmd.clr_step || cmd.sift;
      ram_wdata = cmd.clr_step ? EMPTY_MARK : (sift_move ? nbr_val : mover);
   end

   ytpq_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (addr_ff),
      .wdata   (ram_wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (ram_a),
      .rdata_b (ram_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         addr_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         addr_ff <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_mode;
         val_ff    <= req_value;
         res_ff    <= '0;
         found_ff  <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         if (cmd.set_full) begin
            status_ff <= ST_FULL;
         end
         if (cmd.set_empty) begin
            status_ff <= ST_EMPTY;
            res_ff    <= EMPTY_MARK;
         end
         if (cmd.cap_min) begin
            res_ff <= rd_a;
         end
         if (cmd.set_found) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_res_ff    <= res_ff;
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_found_ff, rsp_res_ff};

   always_comb begin
      stat.op         = op_ff;
      stat.val_empty  = (val_ff == EMPTY_MARK);
      stat.cell_empty = (rd_a == EMPTY_MARK);
      stat.sift_move  = sift_move;
      stat.hit        = (rd_a == val_ff);
      stat.cell_gt    = (rd_a > val_ff);
      stat.at_left    = (col_ff == '0);
      stat.at_bottom  = (row_ff == ROW_LAST);
      stat.clr_last   = (addr_ff == ADDR_LAST);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule
`default_nettype wire

// ===== hdl/young_tableau_priority_queue_unit.sv =====
// Top level of the Young tableau min-priority queue.
//
// Keeps a ROWS x COLS Young tableau of signed 32-bit values, rows and columns
// ascending, 2147483647 marking an empty cell. Each request beat carries a mode
// (insert, extract minimum, search) and a value; each gives exactly one
// response beat. After reset the block sweeps the cell memory to empty, one
// cell a cycle, and accepts nothing until every cell is empty. One item is
// worked at a time: an insert or extract moves at most ROWS+COLS-2 cells, an
// insert dropped because full or an extract on an empty tableau moves none,
// and a search walks left or down from the top-right cell. Each sift step
// compares both neighbours, read over the two registered read ports of the
// cell memory. A finished response is held in an output register, and the next
// request is accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none
module young_tableau_priority_queue_unit import ytpq_pkg::*; #(
   parameter int ROWS = 8,
   parameter int COLS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // mode[1:0], value[33:2], zero pad
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata   // result_value[31:0], found[32],
                                                   // status[34:33], zero pad
);

   cmd_type  cmd;
   stat_type stat;

   ytpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ytpq_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
`default_nettype wire
